/* rtl/lbp_pkg.sv */
// ----------------------------------------------------------------------------
// lbp_pkg: shared types and constants of the LSB bit packer
// Holds the command passed from the front end to the packing back end, the
// result record and the fixed field widths.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned WidthW = 6;

  // Reset value of the bits-per-word register.
  localparam logic [WidthW-1:0] BitsPerWordReset = 6'd32;
  // Widths of zero or above this are treated as the full data word.
  localparam logic [WidthW-1:0] MaxWidth         = 6'd32;

  // Depth of the command queue between front end and back end.
  localparam int unsigned CmdDepth = 2;

  typedef struct packed {
    logic [DataW-1:0]  kept;   // input word with the unused high bits cleared
    logic [WidthW-1:0] width;  // effective number of kept bits
    logic              last;   // flush pending bits after this word
  } cmd_t;

  localparam int unsigned CmdW = $bits(cmd_t);

  typedef struct packed {
    logic [DataW-1:0]  packed_word;
    logic [WidthW-1:0] valid_bits;
    logic              last_of_run;
  } res_t;

endpackage

/* rtl/lbp_stream_if.sv */
// ----------------------------------------------------------------------------
// lbp_in_if / lbp_out_if: valid/ready channels of the LSB bit packer
// The input channel carries data words, the output channel packed words.
// ----------------------------------------------------------------------------
interface lbp_in_if;
  logic                       valid;
  logic                       ready;
  logic [lbp_pkg::DataW-1:0]  data_word;
  logic                       end_of_data;

  modport source (output valid, output data_word, output end_of_data, input ready);
  modport sink   (input valid, input data_word, input end_of_data, output ready);
endinterface

interface lbp_out_if;
  logic                       valid;
  logic                       ready;
  logic [lbp_pkg::DataW-1:0]  packed_word;
  logic [lbp_pkg::WidthW-1:0] valid_bits;
  logic                       last_of_run;

  modport source (output valid, output packed_word, output valid_bits,
                  output last_of_run, input ready);
  modport sink   (input valid, input packed_word, input valid_bits,
                  input last_of_run, output ready);
endinterface

/* rtl/lbp_fifo.sv */
// ----------------------------------------------------------------------------
// lbp_fifo: small synchronous queue
// Register based first-in first-out queue with valid/ready on both sides.
// ----------------------------------------------------------------------------
module lbp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/lbp_front.sv */
// ----------------------------------------------------------------------------
// lbp_front: input front end of the LSB bit packer
// Holds the bits-per-word register, resolves the effective width and clears
// the unused high bits of each accepted word before queueing it.
// ----------------------------------------------------------------------------
module lbp_front #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lbp_pkg::WidthW-1:0] cfg_wdata_i,
  lbp_in_if.sink                     in_if,
  output logic                       cmd_valid_o,
  input  logic                       cmd_ready_i,
  output lbp_pkg::cmd_t              cmd_o
);

  logic [lbp_pkg::WidthW-1:0] bits_per_word_q;
  logic [lbp_pkg::WidthW-1:0] width;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_per_word_q <= lbp_pkg::BitsPerWordReset;
    end else if (cfg_we_i) begin
      bits_per_word_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    width = bits_per_word_q;
    if (width == '0 || width > lbp_pkg::MaxWidth) begin
      width = lbp_pkg::MaxWidth;
    end
    // One input word never fills more than one output word.
    if (7'(width) > 7'(WORD_BITS)) begin
      width = lbp_pkg::WidthW'(WORD_BITS);
    end
  end

  assign in_if.ready  = cmd_ready_i;
  assign cmd_valid_o  = in_if.valid;
  assign cmd_o.kept   = in_if.data_word & ~({lbp_pkg::DataW{1'b1}} << width);
  assign cmd_o.width  = width;
  assign cmd_o.last   = in_if.end_of_data;

endmodule

/* rtl/lbp_back.sv */
// ----------------------------------------------------------------------------
// lbp_back: packing back end of the LSB bit packer
// Merges queued words into the accumulator, forms the full and tail words and
// hands them out one per cycle, if ready, via an output register and a spare.
// ----------------------------------------------------------------------------
module lbp_back #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  lbp_pkg::cmd_t cmd_i,
  lbp_out_if.source     out_if
);

  localparam int unsigned FillW = $clog2(WORD_BITS);
  localparam int unsigned SumW  = FillW + 1;

  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [FillW-1:0]     fill_q, fill_d;
  lbp_pkg::res_t        out_q, out_d, pend_q, pend_d;
  logic                 out_vld_q, out_vld_d, pend_vld_q, pend_vld_d;

  logic [WORD_BITS-1:0] kept_w, placed, merged, rem, acc_nx;
  logic [SumW-1:0]      sum, used, fill_sum;
  logic [FillW-1:0]     fill_nx;
  logic                 full, tail_v, pop, take;
  lbp_pkg::res_t        res_full, res_tail;

  assign kept_w = WORD_BITS'(cmd_i.kept);
  assign placed = kept_w << fill_q;
  assign merged = acc_q | placed;
  assign sum    = SumW'(fill_q) + SumW'(cmd_i.width);
  assign full   = (sum >= SumW'(WORD_BITS));
  assign used   = SumW'(WORD_BITS) - SumW'(fill_q);
  // Bits of this word that did not fit start the next output word.
  assign rem    = kept_w >> used;

  assign fill_sum = full ? (sum - SumW'(WORD_BITS)) : sum;
  assign fill_nx  = FillW'(fill_sum);
  assign acc_nx   = full ? rem : merged;
  assign tail_v   = cmd_i.last && (fill_nx != '0);

  assign res_full.packed_word = lbp_pkg::DataW'(merged);
  assign res_full.valid_bits  = lbp_pkg::WidthW'(WORD_BITS);
  assign res_full.last_of_run = !tail_v;
  assign res_tail.packed_word = lbp_pkg::DataW'(acc_nx);
  assign res_tail.valid_bits  = lbp_pkg::WidthW'(fill_nx);
  assign res_tail.last_of_run = 1'b1;

  assign take        = out_vld_q && out_if.ready;
  assign cmd_ready_o = !pend_vld_q && (!out_vld_q || out_if.ready);
  assign pop         = cmd_valid_i && cmd_ready_o;

  always_comb begin
    acc_d      = acc_q;
    fill_d     = fill_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    if (take) begin
      out_d      = pend_q;
      out_vld_d  = pend_vld_q;
      pend_vld_d = 1'b0;
    end
    if (pop) begin
      out_vld_d  = full || tail_v;
      out_d      = full ? res_full : res_tail;
      pend_vld_d = full && tail_v;
      pend_d     = res_tail;
      if (cmd_i.last) begin
        acc_d  = '0;
        fill_d = '0;
      end else begin
        acc_d  = acc_nx;
        fill_d = fill_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      fill_q     <= '0;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      fill_q     <= fill_d;
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.packed_word = out_q.packed_word;
  assign out_if.valid_bits  = out_q.valid_bits;
  assign out_if.last_of_run = out_q.last_of_run;

  // The spare slot only ever holds the second result behind a shown one.
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> out_vld_q)
    else $error("spare result held without a shown result");

  // Bits above the fill level of the accumulator stay clear.
  a_acc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q >> fill_q) == '0)
    else $error("accumulator holds bits above its fill level");

  // A word marked last leaves nothing pending.
  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cmd_i.last) |=> (fill_q == '0 && acc_q == '0))
    else $error("pending bits remain after a flush");

  // A second result always ends the run and follows a full word.
  a_pend_is_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && full && tail_v) |=> (pend_vld_q && pend_q.last_of_run && !out_q.last_of_run))
    else $error("tail result out of order");

endmodule

/* rtl/lsb_bit_packer_core.sv */
// ----------------------------------------------------------------------------
// lsb_bit_packer_core: variable-width LSB-first bit packer
// Keeps the low bits_per_word bits of each input word and packs them into
// output words, flushing a zero-padded tail on the word marked last.
// ----------------------------------------------------------------------------
// The block accepts one input transaction per clock while its command queue
// has room and keeps the low bits_per_word bits (1 to 32; 0 or above 32
// means 32) of each word. Bits are packed LSB first into WORD_BITS-wide
// words; a full word is sent with valid_bits equal to WORD_BITS, and on
// end_of_data any pending bits follow as a zero-padded tail with its bit
// count. last_of_run marks the final result caused by one input. The output
// port moves one result per clock while the receiver is ready, and an input
// that yields both a full word and a tail holds off the next input until its
// tail has left the spare slot. A result passes through the command queue,
// then the output register, before it is shown on the output port. Write
// bits_per_word only while no transaction is in flight.
module lsb_bit_packer_core #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lbp_pkg::WidthW-1:0] cfg_wdata_i,
  lbp_in_if.sink                     in_if,
  lbp_out_if.source                  out_if
);

  logic          fc_valid, fc_ready, bc_valid, bc_ready;
  lbp_pkg::cmd_t fc_cmd, bc_cmd;

  lbp_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .cmd_valid_o(fc_valid),
    .cmd_ready_i(fc_ready),
    .cmd_o      (fc_cmd)
  );

  lbp_fifo #(
    .WIDTH(lbp_pkg::CmdW),
    .DEPTH(lbp_pkg::CmdDepth)
  ) u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fc_valid),
    .push_ready_o(fc_ready),
    .push_data_i (fc_cmd),
    .pop_valid_o (bc_valid),
    .pop_ready_i (bc_ready),
    .pop_data_o  (bc_cmd)
  );

  lbp_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(bc_valid),
    .cmd_ready_o(bc_ready),
    .cmd_i      (bc_cmd),
    .out_if     (out_if)
  );

endmodule
